/* sv/nrp_pkg.sv */
// shared constants, types and saturation helpers for the newton root finder
`default_nettype none
package nrp_pkg;

	localparam int unsigned MaxIterDefault = 64;
	localparam int unsigned ValW = 48;

	localparam logic signed [47:0] ValMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ValMin = -48'sh8000_0000_0000;
	localparam logic [47:0] OneQ = 48'h0001_0000_0000;

	// reset values of the coefficient and tolerance registers
	localparam logic signed [47:0] C5Reset = 48'sd12884901888;
	localparam logic signed [47:0] C4Reset = -48'sd38654705664;
	localparam logic signed [47:0] C3Reset = 48'sd8589934592;
	localparam logic signed [47:0] C2Reset = -48'sd25769803776;
	localparam logic signed [47:0] C1Reset = -48'sd4294967296;
	localparam logic signed [47:0] C0Reset = 48'sd12884901888;
	localparam logic [46:0] TolReset = 47'd4295;

	// register indexes on the configuration channel
	typedef enum logic [2:0] {
		REG_C5 = 3'd0,
		REG_C4 = 3'd1,
		REG_C3 = 3'd2,
		REG_C2 = 3'd3,
		REG_C1 = 3'd4,
		REG_C0 = 3'd5,
		REG_TOL = 3'd6
	} reg_idx_t;

	// magnitude of a signed value, -2^47 gives 2^47
	function automatic logic [47:0] mag48(input logic signed [47:0] a);
		logic [47:0] r;
		r = a[47] ? 48'(-a) : 48'(a);
		return r;
	endfunction

	// signed value from sign and magnitude, clamped to 48 bits
	function automatic logic signed [47:0] sat_mag(input logic neg, input logic [63:0] mag);
		logic signed [47:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000_0000) r = ValMin;
			else r = -$signed(mag[47:0]);
		end else begin
			if (mag > 64'h7FFF_FFFF_FFFF) r = ValMax;
			else r = $signed(mag[47:0]);
		end
		return r;
	endfunction

	// clamp a wide signed sum to 48 bits
	function automatic logic signed [47:0] sat51(input logic signed [50:0] s);
		logic signed [47:0] r;
		if (s > 51'sh0_7FFF_FFFF_FFFF) r = ValMax;
		else if (s < -51'sh0_8000_0000_0000) r = ValMin;
		else r = s[47:0];
		return r;
	endfunction

	function automatic logic signed [50:0] sx51(input logic signed [47:0] a);
		return {{3{a[47]}}, a};
	endfunction

	// derivative coefficient k*c, k from 2 to 5, clamped
	function automatic logic signed [47:0] scale_coef(input logic signed [47:0] c,
			input logic [2:0] k);
		logic signed [50:0] e;
		logic signed [50:0] s;
		e = sx51(c);
		case (k)
			3'd2: s = e <<< 1;
			3'd3: s = (e <<< 1) + e;
			3'd4: s = e <<< 2;
			3'd5: s = (e <<< 2) + e;
			default: s = e;
		endcase
		return sat51(s);
	endfunction

endpackage
`default_nettype wire

/* sv/nrp_mul.sv */
// iterative 48x48 unsigned fixed point multiplier, four 24x24 partial products
`default_nettype none
module nrp_mul import nrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [47:0] a,
	input  wire logic [47:0] b,
	output logic             done,
	output logic [63:0]      prod
);

	logic [47:0] a_q, b_q;
	logic [95:0] acc_q;
	logic [1:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [23:0] op_a, op_b;
	logic [47:0] pp;
	logic [95:0] pp_sh;

	// pick the partial product for this cycle
	always_comb begin
		op_a = cnt_q[1] ? a_q[47:24] : a_q[23:0];
		op_b = cnt_q[0] ? b_q[47:24] : b_q[23:0];
		pp = 48'(op_a) * 48'(op_b);
		case (cnt_q)
			2'd0: pp_sh = 96'(pp);
			2'd1, 2'd2: pp_sh = 96'(pp) << 24;
			2'd3: pp_sh = 96'(pp) << 48;
			default: pp_sh = '0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator starts at one half lsb so the result comes out rounded
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			acc_q <= 96'h0000_0000_0000_0000_8000_0000;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q[95:32];

endmodule
`default_nettype wire

/* sv/nrp_div.sv */
// restoring divider, one quotient bit a cycle, quotient of num*2^32 by den
`default_nettype none
module nrp_div import nrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [47:0] num,
	input  wire logic [47:0] den,
	output logic             done,
	output logic [48:0]      quo
);

	localparam int unsigned Steps = 80;

	logic [79:0] dvd_q;
	logic [47:0] rem_q;
	logic [47:0] den_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [48:0] r2;
	logic        ge;
	logic [48:0] diff;

	// trial subtract
	always_comb begin
		r2 = {rem_q, dvd_q[79]};
		diff = r2 - {1'b0, den_q};
		ge = (r2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(Steps - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out on top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= {num, 32'd0};
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			dvd_q <= {dvd_q[78:0], ge};
			rem_q <= ge ? diff[47:0] : r2[47:0];
		end
	end

	assign done = done_q;
	assign quo = (|dvd_q[79:48]) ? 49'h1_0000_0000_0000 : {1'b0, dvd_q[47:0]};

endmodule
`default_nettype wire

/* sv/newton_polynomial_root.sv */
// newton-raphson root finder for a quintic, signed Q16.32, with a shared multiplier and a divider
//
// Pulse start with busy low to launch a run from start_value. busy stays high for the whole
// run; the result (root, iterations, converged, zero_slope) is shown for one cycle with done
// high and must be taken then. Each Newton step takes ten products on the shared multiplier
// (four partial products each), one bit-serial division and one update state, and a run
// lasts up to MAX_ITER-1 steps. A zero derivative ends the run after the derivative
// evaluation of that step. The configuration channel is always ready; write it only while
// busy is low.
`default_nettype none
module newton_polynomial_root import nrp_pkg::*; #(
	parameter int unsigned MAX_ITER = MaxIterDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [47:0] start_value,
	output logic                    done,
	output logic signed [47:0]      root,
	output logic [5:0]              iterations,
	output logic                    converged,
	output logic                    zero_slope,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [47:0]        cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DSTART = 11'b00000000010,
		S_DWAIT  = 11'b00000000100,
		S_PSTART = 11'b00000001000,
		S_PWAIT  = 11'b00000010000,
		S_VSTART = 11'b00000100000,
		S_VWAIT  = 11'b00001000000,
		S_UPD    = 11'b00010000000,
		S_TSTART = 11'b00100000000,
		S_TWAIT  = 11'b01000000000,
		S_SPARE  = 11'b10000000000
	} state_t;

	state_t state_q;

	logic signed [47:0] c5_q, c4_q, c3_q, c2_q, c1_q, c0_q;
	logic [46:0]        tol_q;

	logic signed [47:0] x_q, acc_q, d_q, qs_q;
	logic [48:0]        dmag_q;
	logic [47:0]        ax_q;
	logic [5:0]         steps_q;
	logic [2:0]         k_q;

	logic signed [47:0] root_q;
	logic [5:0]         iter_q;
	logic               conv_q, zs_q, done_q;

	logic        mul_go, mul_done;
	logic [47:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        div_go, div_done;
	logic [48:0] div_q;

	logic signed [47:0] mprod, addend, acc_nx, xn;
	logic signed [50:0] diff;
	logic [6:0]         steps_nx;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c5_q <= C5Reset;
			c4_q <= C4Reset;
			c3_q <= C3Reset;
			c2_q <= C2Reset;
			c1_q <= C1Reset;
			c0_q <= C0Reset;
			tol_q <= TolReset;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_C5: c5_q <= cfg_data;
				REG_C4: c4_q <= cfg_data;
				REG_C3: c3_q <= cfg_data;
				REG_C2: c2_q <= cfg_data;
				REG_C1: c1_q <= cfg_data;
				REG_C0: c0_q <= cfg_data;
				REG_TOL: tol_q <= cfg_data[46:0];
				default: ;
			endcase
		end
	end

	// shared units
	assign mul_go = (state_q == S_DSTART) || (state_q == S_PSTART) || (state_q == S_TSTART);
	assign mul_a = (state_q == S_TSTART) ? {1'b0, tol_q} : mag48(acc_q);
	assign mul_b = (state_q == S_TSTART) ? ax_q : mag48(x_q);
	assign div_go = (state_q == S_VSTART);

	nrp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	nrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (mag48(acc_q)),
		.den    (mag48(d_q)),
		.done   (div_done),
		.quo    (div_q)
	);

	// horner step: product plus next coefficient
	always_comb begin
		mprod = sat_mag(acc_q[47] ^ x_q[47], mul_p);
		if (state_q == S_DWAIT) begin
			case (k_q)
				3'd0: addend = scale_coef(c4_q, 3'd4);
				3'd1: addend = scale_coef(c3_q, 3'd3);
				3'd2: addend = scale_coef(c2_q, 3'd2);
				default: addend = c1_q;
			endcase
		end else begin
			case (k_q)
				3'd0: addend = c4_q;
				3'd1: addend = c3_q;
				3'd2: addend = c2_q;
				3'd3: addend = c1_q;
				default: addend = c0_q;
			endcase
		end
		acc_nx = sat51(sx51(mprod) + sx51(addend));
		xn = sat51(sx51(x_q) - sx51(qs_q));
		diff = sx51(xn) - sx51(x_q);
		steps_nx = {1'b0, steps_q} + 7'd1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			steps_q <= '0;
			k_q <= '0;
			root_q <= '0;
			iter_q <= '0;
			conv_q <= 1'b0;
			zs_q <= 1'b0;
			x_q <= '0;
			acc_q <= '0;
			d_q <= '0;
			qs_q <= '0;
			dmag_q <= '0;
			ax_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q <= start_value;
						steps_q <= '0;
						acc_q <= scale_coef(c5_q, 3'd5);
						k_q <= '0;
						state_q <= S_DSTART;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (mul_done) begin
						k_q <= k_q + 3'd1;
						acc_q <= acc_nx;
						state_q <= S_DSTART;
						if (k_q == 3'd3) begin
							if (acc_nx == '0) begin
								root_q <= x_q;
								iter_q <= steps_q;
								conv_q <= 1'b0;
								zs_q <= 1'b1;
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								d_q <= acc_nx;
								acc_q <= c5_q;
								k_q <= '0;
								state_q <= S_PSTART;
							end
						end
					end
				end
				S_PSTART: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (mul_done) begin
						k_q <= k_q + 3'd1;
						acc_q <= acc_nx;
						state_q <= (k_q == 3'd4) ? S_VSTART : S_PSTART;
					end
				end
				S_VSTART: state_q <= S_VWAIT;
				S_VWAIT: begin
					if (div_done) begin
						qs_q <= sat_mag(acc_q[47] ^ d_q[47], 64'(div_q));
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					x_q <= xn;
					steps_q <= steps_nx[5:0];
					dmag_q <= diff[50] ? 49'(-diff) : 49'(diff);
					ax_q <= (mag48(xn) < OneQ) ? OneQ : mag48(xn);
					state_q <= S_TSTART;
				end
				S_TSTART: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (mul_done) begin
						if (64'(dmag_q) < mul_p || steps_nx >= 7'(MAX_ITER)) begin
							root_q <= x_q;
							iter_q <= steps_q;
							conv_q <= (64'(dmag_q) < mul_p);
							zs_q <= 1'b0;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							acc_q <= scale_coef(c5_q, 3'd5);
							k_q <= '0;
							state_q <= S_DSTART;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign root = root_q;
	assign iterations = iter_q;
	assign converged = conv_q;
	assign zero_slope = zs_q;

endmodule
`default_nettype wire

/* tb/newton_polynomial_root_tb.sv */
// self-checking testbench for the newton polynomial root finder
`timescale 1ns / 1ps
module newton_polynomial_root_tb;
	import nrp_pkg::*;

	typedef struct packed {
		logic signed [47:0] root;
		logic [5:0]         iterations;
		logic               converged;
		logic               zero_slope;
	} root_word_t;

	localparam int unsigned WatchdogLimit = 40000;
	localparam int unsigned SettleCycles = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [47:0] start_value;
	logic done;
	logic signed [47:0] root;
	logic [5:0] iterations;
	logic converged;
	logic zero_slope;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;

	// predictor copy of the configuration
	logic signed [47:0] coef [0:5];
	logic [46:0] tol_q;

	root_word_t expected_roots[$];
	int errors;
	int words_sent;
	int words_checked;
	int idle_pct;
	int idle_cycles;
	int converged_seen;
	int zero_slope_seen;
	int limit_seen;

	newton_polynomial_root u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_value(start_value), .done(done), .root(root),
		.iterations(iterations), .converged(converged), .zero_slope(zero_slope),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// fixed point helpers
	function automatic logic signed [47:0] clamp_mag(input logic neg, input logic [97:0] mag);
		logic signed [47:0] r;
		if (neg) begin
			if (mag > 98'h8000_0000_0000) r = ValMin;
			else r = 48'(-$signed({1'b0, mag[47:0]}));
		end else begin
			if (mag > 98'h7FFF_FFFF_FFFF) r = ValMax;
			else r = $signed(mag[47:0]);
		end
		return r;
	endfunction

	function automatic logic [47:0] abs_val(input logic signed [47:0] a);
		logic signed [48:0] w;
		w = 49'(a);
		if (w < 0) w = -w;
		return w[47:0];
	endfunction

	function automatic logic signed [47:0] add_clamp(input logic signed [47:0] a,
			input logic signed [47:0] b);
		logic signed [49:0] s;
		s = 50'(a) + 50'(b);
		if (s > 50'sh7FFF_FFFF_FFFF) return ValMax;
		if (s < -50'sh8000_0000_0000) return ValMin;
		return s[47:0];
	endfunction

	function automatic logic signed [47:0] sub_clamp(input logic signed [47:0] a,
			input logic signed [47:0] b);
		logic signed [49:0] s;
		s = 50'(a) - 50'(b);
		if (s > 50'sh7FFF_FFFF_FFFF) return ValMax;
		if (s < -50'sh8000_0000_0000) return ValMin;
		return s[47:0];
	endfunction

	function automatic logic [97:0] q_mul_mag(input logic [47:0] a, input logic [47:0] b);
		logic [97:0] p;
		p = 98'(a) * 98'(b) + 98'h8000_0000;
		return p >> 32;
	endfunction

	function automatic logic signed [47:0] q_mul(input logic signed [47:0] a,
			input logic signed [47:0] b);
		return clamp_mag(a[47] != b[47], q_mul_mag(abs_val(a), abs_val(b)));
	endfunction

	function automatic logic signed [47:0] q_div(input logic signed [47:0] n,
			input logic signed [47:0] d);
		logic [97:0] q;
		q = ({50'd0, abs_val(n)} << 32) / 98'(abs_val(d));
		return clamp_mag(n[47] != d[47], q);
	endfunction

	function automatic logic signed [47:0] scaled_coef(input logic signed [47:0] c, input int k);
		logic signed [51:0] s;
		s = 52'(c) * k;
		if (s > 52'sh7FFF_FFFF_FFFF) return ValMax;
		if (s < -52'sh8000_0000_0000) return ValMin;
		return s[47:0];
	endfunction

	function automatic logic signed [47:0] eval_poly(input logic signed [47:0] x);
		logic signed [47:0] acc;
		acc = coef[0];
		for (int i = 1; i < 6; i++) acc = add_clamp(q_mul(acc, x), coef[i]);
		return acc;
	endfunction

	function automatic logic signed [47:0] eval_slope(input logic signed [47:0] x);
		logic signed [47:0] acc;
		acc = scaled_coef(coef[0], 5);
		for (int i = 1; i < 5; i++) acc = add_clamp(q_mul(acc, x), scaled_coef(coef[i], 5 - i));
		return acc;
	endfunction

	// run the newton iteration the way the block should
	function automatic root_word_t solve_root(input logic signed [47:0] x0);
		root_word_t r;
		logic signed [47:0] x;
		logic signed [47:0] xn;
		logic signed [47:0] d;
		logic signed [48:0] diff;
		logic [47:0] ax;
		logic [97:0] thr;
		int steps;
		x = x0;
		steps = 0;
		r.converged = 1'b0;
		r.zero_slope = 1'b0;
		while (steps + 1 < MaxIterDefault) begin
			d = eval_slope(x);
			if (d == 0) begin
				r.zero_slope = 1'b1;
				break;
			end
			xn = sub_clamp(x, q_div(eval_poly(x), d));
			diff = 49'(xn) - 49'(x);
			x = xn;
			steps++;
			ax = abs_val(xn);
			if (ax < OneQ) ax = OneQ;
			thr = q_mul_mag({1'b0, tol_q}, ax);
			if (diff < 0) diff = -diff;
			if (98'(diff) < thr) begin
				r.converged = 1'b1;
				break;
			end
		end
		r.root = x;
		r.iterations = 6'(steps);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_roots.size() == 0) begin
				$display("%0t: unexpected result word root=%0d", $time, root);
				errors++;
			end else begin
				root_word_t e;
				e = expected_roots.pop_front();
				words_checked++;
				if (e.root !== root) begin
					$display("%0t: root expected %0d actual %0d", $time, e.root, root);
					errors++;
				end
				if (e.iterations !== iterations) begin
					$display("%0t: iterations expected %0d actual %0d", $time,
						e.iterations, iterations);
					errors++;
				end
				if (e.converged !== converged) begin
					$display("%0t: converged expected %0b actual %0b", $time,
						e.converged, converged);
					errors++;
				end
				if (e.zero_slope !== zero_slope) begin
					$display("%0t: zero_slope expected %0b actual %0b", $time,
						e.zero_slope, zero_slope);
					errors++;
				end
				if (e.converged) converged_seen++;
				if (e.zero_slope) zero_slope_seen++;
				if (!e.converged && !e.zero_slope) limit_seen++;
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_start(input logic signed [47:0] x0);
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1'b1;
		start_value <= x0;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_roots.push_back(solve_root(x0));
		words_sent++;
		start <= 1'b0;
		start_value <= 48'($urandom()) ^ {$urandom(), 16'h0};
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_roots.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_TOL) tol_q = val[46:0];
		else coef[int'(idx)] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coefs(input logic signed [47:0] c5, c4, c3, c2, c1, c0,
			input logic [46:0] tol);
		wait_drained();
		write_reg(REG_C5, c5);
		write_reg(REG_C4, c4);
		write_reg(REG_C3, c3);
		write_reg(REG_C2, c2);
		write_reg(REG_C1, c1);
		write_reg(REG_C0, c0);
		write_reg(REG_TOL, {1'b0, tol});
	endtask

	function automatic logic signed [47:0] small_x();
		return $signed(48'($urandom_range(32'h7_FFFF_FFF))) - 48'sh4_0000_0000 +
			$signed(48'($urandom()));
	endfunction

	// start values at the extremes and around the default roots
	task automatic test_directed_starts();
		idle_pct = 0;
		send_start(48'sd0);
		send_start(ValMax);
		send_start(ValMin);
		send_start(48'sh1_0000_0000);
		send_start(-48'sh1_0000_0000);
		send_start(48'sh3_0000_0000);
		send_start(48'sh0_8000_0000);
		send_start(48'sh5555_5555_5555);
		send_start(-48'sh2AAA_AAAA_AAAA);
		send_start(48'sd1);
		send_start(-48'sd1);
	endtask

	// special cases: zero slope everywhere, iteration limit, saturation
	task automatic test_special_cases();
		// constant polynomial: derivative is zero at once
		load_coefs(0, 0, 0, 0, 0, 48'sh1_0000_0000, TolReset);
		send_start(48'sh2_0000_0000);
		// x^2 + 1 has no real root, zero slope at zero, otherwise runs to the limit
		load_coefs(0, 0, 0, 48'sh1_0000_0000, 0, 48'sh1_0000_0000, 47'd0);
		send_start(48'sd0);
		send_start(48'sh0_3000_0000);
		// huge coefficients drive sums and products into saturation
		load_coefs(ValMax, ValMin, ValMax, ValMin, ValMax, ValMin, 47'h7FFF_FFFF_FFFF);
		send_start(48'sh7_0000_0000);
		send_start(ValMin);
		send_start(48'sh1_0000);
		load_coefs(ValMin, ValMax, 0, 0, ValMin, ValMax, 47'd1);
		send_start(-48'sh3_0000_0000);
		send_start(ValMax);
	endtask

	// random start values across several register settings and idle mixes
	task automatic test_random_runs(input int n);
		for (int k = 0; k < n; k++) begin
			if (k % 15 == 0) begin
				wait_drained();
				repeat (SettleCycles) @(posedge clk);
				if (k % 30 == 0)
					load_coefs(C5Reset, C4Reset, C3Reset, C2Reset, C1Reset, C0Reset, TolReset);
				else
					load_coefs(small_x(), small_x(), small_x(), small_x(), small_x(),
						small_x(), 47'($urandom_range(1 << 20)));
			end
			case ((k / 20) % 4)
				0: idle_pct = 0;
				1: idle_pct = 66;
				2: idle_pct = 31;
				default: idle_pct = 66;
			endcase
			if ($urandom_range(9) == 0)
				send_start({$urandom(), 16'($urandom())});
			else
				send_start(small_x());
			// hold off until the block has delivered everything
			if (k == n / 2) wait_drained();
		end
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		idle_pct = 0;
		idle_cycles = 0;
		converged_seen = 0;
		zero_slope_seen = 0;
		limit_seen = 0;
		coef[0] = C5Reset;
		coef[1] = C4Reset;
		coef[2] = C3Reset;
		coef[3] = C2Reset;
		coef[4] = C1Reset;
		coef[5] = C0Reset;
		tol_q = TolReset;
		arst_n = 1'b0;
		start = 1'b0;
		start_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_C5;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_starts();
		test_special_cases();
		test_random_runs(110);
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		$display("%0d start values sent, %0d results checked", words_sent, words_checked);
		$display("%0d converged, %0d zero slope, %0d hit the step limit",
			converged_seen, zero_slope_seen, limit_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
